// ===== rtl/ebalu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebalu_pkg
// Shared types and operation codes of the eight-bit cpu alu with flags.
// ----------------------------------------------------------------------------
package ebalu_pkg;

	// operation codes
	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC   = 5'd8,
		OP_DEC   = 5'd9,
		OP_RLC   = 5'd10,
		OP_RRC   = 5'd11,
		OP_RL    = 5'd12,
		OP_RR    = 5'd13,
		OP_SLA   = 5'd14,
		OP_SRA   = 5'd15,
		OP_SWAP  = 5'd16,
		OP_SRL   = 5'd17,
		OP_BIT   = 5'd18,
		OP_RES   = 5'd19,
		OP_SET   = 5'd20,
		OP_RLCA  = 5'd21,
		OP_RRCA  = 5'd22,
		OP_RLA   = 5'd23,
		OP_RRA   = 5'd24,
		OP_DAA   = 5'd25,
		OP_CPL   = 5'd26,
		OP_SCF   = 5'd27,
		OP_CCF   = 5'd28,
		OP_ADD16 = 5'd29,
		OP_ADDSP = 5'd30,
		OP_NOP   = 5'd31
	} alu_op_t;

	// shifter kinds, same order as the cb shift opcodes
	typedef enum logic [2:0] {
		SH_RLC  = 3'd0,
		SH_RRC  = 3'd1,
		SH_RL   = 3'd2,
		SH_RR   = 3'd3,
		SH_SLA  = 3'd4,
		SH_SRA  = 3'd5,
		SH_SWAP = 3'd6,
		SH_SRL  = 3'd7
	} shift_kind_t;

	// input item
	typedef struct packed {
		logic [4:0]  op_select;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [2:0]  bit_index;
		logic        flag_z_in;
		logic        flag_n_in;
		logic        flag_h_in;
		logic        flag_c_in;
	} alu_in_t;

	// result item
	typedef struct packed {
		logic [15:0] result_value;
		logic        writes_back;
		logic        flag_z_out;
		logic        flag_n_out;
		logic        flag_h_out;
		logic        flag_c_out;
	} alu_out_t;

endpackage

// ===== rtl/ebalu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebalu_core
// Combinational datapath: one operation, result value, write-back and flags.
// ----------------------------------------------------------------------------
module ebalu_core import ebalu_pkg::*; (
	input  alu_in_t  op_item,
	output alu_out_t res_item
);

	// rotate / shift unit, returns {carry, result}
	function automatic logic [8:0] shift8(input logic [2:0] kind, input logic [7:0] v,
			input logic cin);
		logic [8:0] r;
		r = 9'd0;
		case (kind)
			SH_RLC:  r = {v[7], v[6:0], v[7]};
			SH_RRC:  r = {v[0], v[0], v[7:1]};
			SH_RL:   r = {v[7], v[6:0], cin};
			SH_RR:   r = {v[0], cin, v[7:1]};
			SH_SLA:  r = {v[7], v[6:0], 1'b0};
			SH_SRA:  r = {v[0], v[7], v[7:1]};
			SH_SWAP: r = {1'b0, v[3:0], v[7:4]};
			SH_SRL:  r = {v[0], 1'b0, v[7:1]};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	logic [7:0]  a8;
	logic [7:0]  b8;
	logic        ci;
	logic [8:0]  add9;
	logic [4:0]  add_lo5;
	logic [8:0]  sub9;
	logic [4:0]  sub_lo5;
	logic [7:0]  bmask;
	logic [4:0]  cb_kind_w;
	logic [4:0]  acc_kind_w;
	logic [8:0]  cb_sh;
	logic [8:0]  acc_sh;
	logic [7:0]  daa_adj;
	logic        daa_c;
	logic [7:0]  daa_res;
	logic [16:0] add17;
	logic [12:0] add_lo13;
	logic [15:0] sp_ext;
	logic [4:0]  sp_lo5;
	logic [8:0]  sp_lo9;

	// shared arithmetic
	always_comb begin
		a8      = op_item.operand_a[7:0];
		b8      = op_item.operand_b[7:0];
		ci      = ((op_item.op_select == OP_ADC) || (op_item.op_select == OP_SBC)) ?
			op_item.flag_c_in : 1'b0;
		add9    = {1'b0, a8} + {1'b0, b8} + {8'd0, ci};
		add_lo5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, ci};
		sub9    = {1'b0, a8} - {1'b0, b8} - {8'd0, ci};
		sub_lo5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, ci};
		bmask   = 8'd1 << op_item.bit_index;
		cb_kind_w  = op_item.op_select - OP_RLC;
		acc_kind_w = op_item.op_select - OP_RLCA;
		cb_sh   = shift8(cb_kind_w[2:0], b8, op_item.flag_c_in);
		acc_sh  = shift8(acc_kind_w[2:0], a8, op_item.flag_c_in);
		add17   = {1'b0, op_item.operand_a} + {1'b0, op_item.operand_b};
		add_lo13 = {1'b0, op_item.operand_a[11:0]} + {1'b0, op_item.operand_b[11:0]};
		sp_ext  = {{8{b8[7]}}, b8};
		sp_lo5  = {1'b0, op_item.operand_a[3:0]} + {1'b0, b8[3:0]};
		sp_lo9  = {1'b0, op_item.operand_a[7:0]} + {1'b0, b8};
	end

	// decimal adjust
	always_comb begin
		daa_adj = 8'd0;
		daa_c   = op_item.flag_c_in;
		if (op_item.flag_h_in || (!op_item.flag_n_in && (a8[3:0] > 4'h9))) begin
			daa_adj = daa_adj | 8'h06;
		end
		if (op_item.flag_c_in || (!op_item.flag_n_in && (a8 > 8'h99))) begin
			daa_adj = daa_adj | 8'h60;
			daa_c   = 1'b1;
		end
		daa_res = op_item.flag_n_in ? (a8 - daa_adj) : (a8 + daa_adj);
	end

	// operation select and flag update
	always_comb begin
		res_item.result_value = 16'd0;
		res_item.writes_back  = 1'b1;
		res_item.flag_z_out   = op_item.flag_z_in;
		res_item.flag_n_out   = op_item.flag_n_in;
		res_item.flag_h_out   = op_item.flag_h_in;
		res_item.flag_c_out   = op_item.flag_c_in;
		case (op_item.op_select) inside
			OP_ADD, OP_ADC: begin
				res_item.result_value = {8'd0, add9[7:0]};
				res_item.flag_z_out   = (add9[7:0] == 8'd0);
				res_item.flag_n_out   = 1'b0;
				res_item.flag_h_out   = add_lo5[4];
				res_item.flag_c_out   = add9[8];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				res_item.result_value = {8'd0, sub9[7:0]};
				res_item.flag_z_out   = (sub9[7:0] == 8'd0);
				res_item.flag_n_out   = 1'b1;
				res_item.flag_h_out   = sub_lo5[4];
				res_item.flag_c_out   = sub9[8];
				if (op_item.op_select == OP_CP) begin
					res_item.result_value = 16'd0;
					res_item.writes_back  = 1'b0;
				end
			end
			OP_AND, OP_XOR, OP_OR: begin
				if (op_item.op_select == OP_AND) begin
					res_item.result_value = {8'd0, a8 & b8};
				end else if (op_item.op_select == OP_XOR) begin
					res_item.result_value = {8'd0, a8 ^ b8};
				end else begin
					res_item.result_value = {8'd0, a8 | b8};
				end
				res_item.flag_z_out = (res_item.result_value[7:0] == 8'd0);
				res_item.flag_n_out = 1'b0;
				res_item.flag_h_out = (op_item.op_select == OP_AND);
				res_item.flag_c_out = 1'b0;
			end
			OP_INC: begin
				res_item.result_value = {8'd0, b8 + 8'd1};
				res_item.flag_z_out   = (b8 == 8'hFF);
				res_item.flag_n_out   = 1'b0;
				res_item.flag_h_out   = (b8[3:0] == 4'hF);
			end
			OP_DEC: begin
				res_item.result_value = {8'd0, b8 - 8'd1};
				res_item.flag_z_out   = (b8 == 8'h01);
				res_item.flag_n_out   = 1'b1;
				res_item.flag_h_out   = (b8[3:0] == 4'h0);
			end
			[OP_RLC:OP_SRL]: begin
				res_item.result_value = {8'd0, cb_sh[7:0]};
				res_item.flag_z_out   = (cb_sh[7:0] == 8'd0);
				res_item.flag_n_out   = 1'b0;
				res_item.flag_h_out   = 1'b0;
				res_item.flag_c_out   = cb_sh[8];
			end
			OP_BIT: begin
				res_item.writes_back = 1'b0;
				res_item.flag_z_out  = ((b8 & bmask) == 8'd0);
				res_item.flag_n_out  = 1'b0;
				res_item.flag_h_out  = 1'b1;
			end
			OP_RES: begin
				res_item.result_value = {8'd0, b8 & ~bmask};
			end
			OP_SET: begin
				res_item.result_value = {8'd0, b8 | bmask};
			end
			[OP_RLCA:OP_RRA]: begin
				res_item.result_value = {8'd0, acc_sh[7:0]};
				res_item.flag_z_out   = 1'b0;
				res_item.flag_n_out   = 1'b0;
				res_item.flag_h_out   = 1'b0;
				res_item.flag_c_out   = acc_sh[8];
			end
			OP_DAA: begin
				res_item.result_value = {8'd0, daa_res};
				res_item.flag_z_out   = (daa_res == 8'd0);
				res_item.flag_h_out   = 1'b0;
				res_item.flag_c_out   = daa_c;
			end
			OP_CPL: begin
				res_item.result_value = {8'd0, ~a8};
				res_item.flag_n_out   = 1'b1;
				res_item.flag_h_out   = 1'b1;
			end
			OP_SCF, OP_CCF: begin
				res_item.writes_back = 1'b0;
				res_item.flag_n_out  = 1'b0;
				res_item.flag_h_out  = 1'b0;
				res_item.flag_c_out  = (op_item.op_select == OP_SCF) ? 1'b1 :
					~op_item.flag_c_in;
			end
			OP_ADD16: begin
				res_item.result_value = add17[15:0];
				res_item.flag_n_out   = 1'b0;
				res_item.flag_h_out   = add_lo13[12];
				res_item.flag_c_out   = add17[16];
			end
			OP_ADDSP: begin
				res_item.result_value = op_item.operand_a + sp_ext;
				res_item.flag_z_out   = 1'b0;
				res_item.flag_n_out   = 1'b0;
				res_item.flag_h_out   = sp_lo5[4];
				res_item.flag_c_out   = sp_lo9[8];
			end
			default: begin
				// no-operation code: no write-back, flags pass through
				res_item.writes_back = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/eight_bit_cpu_alu_with_flags_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags_unit
// Eight-bit cpu alu with flags: input register, one-pass datapath, result register.
// ----------------------------------------------------------------------------
// an accepted item is captured in the input register, and its result is captured
//   in the result register when that register can advance
// throughput: one item per cycle unless the output stalls; input and result registers
//   form a two-deep pipeline, so an item is taken while a result waits if s1 is empty
// reset: arst_n clears both valid bits; payload registers are not reset
module eight_bit_cpu_alu_with_flags_unit import ebalu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     op_valid,
	output logic     op_stall,
	input  alu_in_t  op,
	output logic     res_valid,
	input  logic     res_stall,
	output alu_out_t res
);

	logic     valid_s1;
	alu_in_t  item_s1;
	logic     valid_s2;
	alu_out_t item_s2;
	alu_out_t core_res;
	logic     adv_s2;
	logic     adv_s1;

	// stage advance: a stage moves when it is empty or the one after it is empty or moving
	assign adv_s2   = !valid_s2 || !res_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign op_stall = !adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && op_valid) begin
			item_s1 <= op;
		end
	end

	// datapath
	ebalu_core u_core (
		.op_item  (item_s1),
		.res_item (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			item_s2 <= core_res;
		end
	end

	assign res_valid = valid_s2;
	assign res       = item_s2;

	// an accepted item sits in the input register next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_stall |=> valid_s1)
		else $error("accepted item missing from input register");

	// a held item is not lost while the result register is blocked
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && res_stall |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while blocked");

	// an item leaving the input register lands in the result register
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("item dropped between stages");

	// stall only when both registers are full and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> valid_s1 && valid_s2 && res_stall)
		else $error("input stalled without cause");

endmodule
